// ===== rtl/rau_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Transaction payload types, operation codes and sequencer states that are
// shared by the rational arithmetic unit and its checker.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int unsigned FieldWidth = 32;
  localparam int unsigned ResWidth   = 64;
  localparam int unsigned FuncWidth  = 3;

  typedef enum logic [FuncWidth-1:0] {
    FUNC_MUL_FRAC = 3'd0,
    FUNC_MUL_INT  = 3'd1,
    FUNC_ADD_FRAC = 3'd2,
    FUNC_ADD_INT  = 3'd3,
    FUNC_COMPARE  = 3'd4
  } func_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GCD,
    ST_GCD_WAIT,
    ST_Q1,
    ST_Q1_WAIT,
    ST_Q2,
    ST_Q2_WAIT,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [FuncWidth-1:0]         func;
    logic signed [FieldWidth-1:0] a_num;
    logic signed [FieldWidth-1:0] a_den;
    logic signed [FieldWidth-1:0] b_num;
    logic signed [FieldWidth-1:0] b_den;
    logic signed [FieldWidth-1:0] scalar;
  } rau_in_t;

  typedef struct packed {
    logic signed [ResWidth-1:0] res_num;
    logic signed [ResWidth-1:0] res_den;
    logic                       is_equal;
    logic                       zero_den_error;
  } rau_out_t;

endpackage
`default_nettype wire

// ===== rtl/rau_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rational arithmetic unit divider
// Iterative signed divider, one quotient bit per cycle, with quotient and
// remainder truncated toward zero.
// ----------------------------------------------------------------------------
module rau_div #(
  parameter int unsigned OW = 33
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [OW-1:0] dividend_i,
  input  logic signed [OW-1:0] divisor_i,
  output logic                 done_o,
  output logic signed [OW-1:0] quo_o,
  output logic signed [OW-1:0] rem_o
);
  import rau_pkg::*;

  localparam int unsigned CW = $clog2(OW + 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [OW-1:0] acc_q, acc_d;
  logic [OW-1:0] qr_q, qr_d;
  logic [OW-1:0] bmag_q, bmag_d;
  logic          negq_q, negq_d;
  logic          negr_q, negr_d;

  logic [OW-1:0] mag_a, mag_b;
  logic [OW:0]   shifted, diff;
  logic          fits;
  logic signed [OW-1:0] q_s, r_s;

  assign mag_a   = dividend_i[OW-1] ? -dividend_i : dividend_i;
  assign mag_b   = divisor_i[OW-1]  ? -divisor_i  : divisor_i;
  assign shifted = {acc_q, qr_q[OW-1]};
  assign diff    = shifted - {1'b0, bmag_q};
  assign fits    = (shifted >= {1'b0, bmag_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    qr_d   = qr_q;
    bmag_d = bmag_q;
    negq_d = negq_q;
    negr_d = negr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(OW);
      acc_d  = '0;
      qr_d   = mag_a;
      bmag_d = mag_b;
      negq_d = dividend_i[OW-1] ^ divisor_i[OW-1];
      negr_d = dividend_i[OW-1];
    end else if (busy_q) begin
      acc_d = fits ? diff[OW-1:0] : shifted[OW-1:0];
      qr_d  = {qr_q[OW-2:0], fits};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    qr_q   <= qr_d;
    bmag_q <= bmag_d;
    negq_q <= negq_d;
    negr_q <= negr_d;
  end

  assign q_s    = $signed(qr_q);
  assign r_s    = $signed(acc_q);
  assign quo_o  = negq_q ? -q_s : q_s;
  assign rem_o  = negr_q ? -r_s : r_s;
  assign done_o = done_q;

endmodule
`default_nettype wire

// ===== rtl/rau_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rational arithmetic unit multiplier
// Shared signed multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
module rau_mul #(
  parameter int unsigned OW = 33
) (
  input  logic                                clk_i,
  input  logic signed [OW-1:0]                a_i,
  input  logic signed [OW-1:0]                b_i,
  output logic signed [rau_pkg::ResWidth-1:0] p_o
);
  import rau_pkg::*;

  logic signed [2*OW-1:0]     prod;
  logic signed [ResWidth-1:0] p_q;

  assign prod = a_i * b_i;

  always_ff @(posedge clk_i) begin
    p_q <= ResWidth'(prod);
  end

  assign p_o = p_q;

endmodule
`default_nettype wire

// ===== rtl/rational_arithmetic_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Multiplies, adds and compares signed fractions under a small sequencer
// that shares one iterative divider and one multiplier.
// ----------------------------------------------------------------------------
// The input channel carries one request per transaction: an operation code,
// two fractions and an integer. The output channel returns exactly one result
// transaction per request: a fraction and the equality and zero-denominator
// flags. Each operand is the low OPERAND_WIDTH bits of its field, sign-extended.
// One request is worked on at a time; in_stall_o is high from the cycle after
// a request is accepted until its result has been moved to the output register.
// An undefined code or a zero denominator goes straight to the done state;
// multiply or add by the integer passes through the MUL0 and MUL1 states, and
// fraction multiply and compare through MUL0 to MUL2. The fraction sum first
// runs Euclid's remainder loop on the shared divider to find g, then divides
// b_den and a_den by g, and then passes through MUL0 to MUL3. Once a result
// is loaded into the output register the sequencer is idle again and the
// next request can be accepted.
// The output register lets a new request be accepted while a finished result
// still waits; a stalled result holds until taken, and a finished request
// then waits in its last state. Reset empties the output register and returns
// the sequencer to idle.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  rau_pkg::rau_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rau_pkg::rau_out_t out_data_o
);
  import rau_pkg::*;

  localparam int unsigned W  = OPERAND_WIDTH;
  localparam int unsigned OW = W + 1;

  // Operands carry one guard bit so that quotients such as the most negative
  // value divided by minus one still fit.
  typedef logic signed [OW-1:0] opnd_t;

  function automatic opnd_t sext_op(logic [FieldWidth-1:0] v);
    return {v[W-1], v[W-1:0]};
  endfunction

  state_e               state_q, state_d;
  logic [FuncWidth-1:0] func_q, func_d;
  opnd_t                an_q, an_d, ad_q, ad_d, bn_q, bn_d, bd_q, bd_d, sc_q, sc_d;
  opnd_t                x_q, x_d, y_q, y_d;
  opnd_t                q1_q, q1_d, q2_q, q2_d;
  logic signed [ResWidth-1:0] acc0_q, acc0_d, acc1_q, acc1_d, acc2_q, acc2_d;
  logic                 err_q, err_d;
  logic                 bad_q, bad_d;
  logic                 out_valid_q, out_valid_d;
  rau_out_t             out_q, out_d;

  logic                 accept;
  logic                 ad_zero, bd_zero;

  // Shared units.
  logic                 div_start, div_done;
  opnd_t                div_a, div_b, div_quo, div_rem;
  opnd_t                mul_a, mul_b;
  logic signed [ResWidth-1:0] mul_p;

  rau_div #(.OW(OW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  rau_mul #(.OW(OW)) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign ad_zero    = (sext_op(in_data_i.a_den) == '0);
  assign bd_zero    = (sext_op(in_data_i.b_den) == '0);

  always_comb begin
    state_d     = state_q;
    func_d      = func_q;
    an_d        = an_q;
    ad_d        = ad_q;
    bn_d        = bn_q;
    bd_d        = bd_q;
    sc_d        = sc_q;
    x_d         = x_q;
    y_d         = y_q;
    q1_d        = q1_q;
    q2_d        = q2_q;
    acc0_d      = acc0_q;
    acc1_d      = acc1_q;
    acc2_d      = acc2_q;
    err_d       = err_q;
    bad_d       = bad_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    div_start   = 1'b0;
    div_a       = x_q;
    div_b       = y_q;
    mul_a       = an_q;
    mul_b       = bn_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          func_d = in_data_i.func;
          an_d   = sext_op(in_data_i.a_num);
          ad_d   = sext_op(in_data_i.a_den);
          bn_d   = sext_op(in_data_i.b_num);
          bd_d   = sext_op(in_data_i.b_den);
          sc_d   = sext_op(in_data_i.scalar);
          x_d    = sext_op(in_data_i.a_den);
          y_d    = sext_op(in_data_i.b_den);
          err_d  = 1'b0;
          bad_d  = 1'b0;
          unique case (func_e'(in_data_i.func))
            FUNC_MUL_FRAC, FUNC_ADD_FRAC, FUNC_COMPARE: err_d = ad_zero || bd_zero;
            FUNC_MUL_INT, FUNC_ADD_INT:                 err_d = ad_zero;
            default:                                    bad_d = 1'b1;
          endcase
          if (err_d || bad_d) begin
            state_d = ST_DONE;
          end else if (func_e'(in_data_i.func) == FUNC_ADD_FRAC) begin
            state_d = ST_GCD;
          end else begin
            state_d = ST_MUL0;
          end
        end
      end
      ST_GCD: begin
        div_start = 1'b1;
        state_d   = ST_GCD_WAIT;
      end
      ST_GCD_WAIT: begin
        if (div_done) begin
          // The last nonzero remainder ends up in x and is the divisor g.
          x_d     = y_q;
          y_d     = div_rem;
          state_d = (div_rem == '0) ? ST_Q1 : ST_GCD;
        end
      end
      ST_Q1: begin
        div_start = 1'b1;
        div_a     = bd_q;
        div_b     = x_q;
        state_d   = ST_Q1_WAIT;
      end
      ST_Q1_WAIT: begin
        if (div_done) begin
          q1_d    = div_quo;
          state_d = ST_Q2;
        end
      end
      ST_Q2: begin
        div_start = 1'b1;
        div_a     = ad_q;
        div_b     = x_q;
        state_d   = ST_Q2_WAIT;
      end
      ST_Q2_WAIT: begin
        if (div_done) begin
          q2_d    = div_quo;
          state_d = ST_MUL0;
        end
      end
      ST_MUL0: begin
        // The sum uses lcm = a_den*(b_den/g), lcm/a_den = b_den/g and
        // lcm/b_den = a_den/g, all exact.
        unique case (func_e'(func_q))
          FUNC_MUL_FRAC: begin mul_a = an_q; mul_b = bn_q; end
          FUNC_MUL_INT:  begin mul_a = an_q; mul_b = sc_q; end
          FUNC_ADD_FRAC: begin mul_a = ad_q; mul_b = q1_q; end
          FUNC_ADD_INT:  begin mul_a = ad_q; mul_b = sc_q; end
          FUNC_COMPARE:  begin mul_a = an_q; mul_b = bd_q; end
          default:       begin mul_a = an_q; mul_b = bn_q; end
        endcase
        state_d = ST_MUL1;
      end
      ST_MUL1: begin
        acc0_d = mul_p;
        unique case (func_e'(func_q))
          FUNC_MUL_FRAC: begin mul_a = ad_q; mul_b = bd_q; state_d = ST_MUL2; end
          FUNC_ADD_FRAC: begin mul_a = q1_q; mul_b = an_q; state_d = ST_MUL2; end
          FUNC_COMPARE:  begin mul_a = bn_q; mul_b = ad_q; state_d = ST_MUL2; end
          default:       state_d = ST_DONE;
        endcase
      end
      ST_MUL2: begin
        acc1_d = mul_p;
        mul_a  = q2_q;
        mul_b  = bn_q;
        state_d = (func_e'(func_q) == FUNC_ADD_FRAC) ? ST_MUL3 : ST_DONE;
      end
      ST_MUL3: begin
        acc2_d  = mul_p;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d                = '0;
          out_d.zero_den_error = err_q;
          if (!err_q && !bad_q) begin
            unique case (func_e'(func_q))
              FUNC_MUL_FRAC: begin
                out_d.res_num = acc0_q;
                out_d.res_den = acc1_q;
              end
              FUNC_MUL_INT: begin
                out_d.res_num = acc0_q;
                out_d.res_den = ResWidth'(ad_q);
              end
              FUNC_ADD_FRAC: begin
                out_d.res_num = acc1_q + acc2_q;
                out_d.res_den = acc0_q;
              end
              FUNC_ADD_INT: begin
                out_d.res_num = acc0_q + ResWidth'(an_q);
                out_d.res_den = ResWidth'(ad_q);
              end
              FUNC_COMPARE:  out_d.is_equal = (acc0_q == acc1_q);
              default:       out_d = '0;
            endcase
          end
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q <= func_d;
    an_q   <= an_d;
    ad_q   <= ad_d;
    bn_q   <= bn_d;
    bd_q   <= bd_d;
    sc_q   <= sc_d;
    x_q    <= x_d;
    y_q    <= y_d;
    q1_q   <= q1_d;
    q2_q   <= q2_d;
    acc0_q <= acc0_d;
    acc1_q <= acc1_d;
    acc2_q <= acc2_d;
    err_q  <= err_d;
    bad_q  <= bad_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// ===== rtl/rau_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rational arithmetic unit checker
// Port-level assertions on the unit's transactions, bound to the top level.
// ----------------------------------------------------------------------------
module rau_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire rau_pkg::rau_in_t  in_data_i,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire rau_pkg::rau_out_t out_data_o
);
  import rau_pkg::*;

  // A stalled result transaction holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // Only one request is in flight: the unit stalls right after accepting.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("unit did not stall after accepting a request");

  // A zero denominator zeroes the whole result.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.zero_den_error |->
      out_data_o.res_num == '0 && out_data_o.res_den == '0 && !out_data_o.is_equal)
    else $error("error result is not zero");

  // A compare result that reports equality carries a zero fraction.
  a_eq_frac_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.is_equal |->
      out_data_o.res_num == '0 && out_data_o.res_den == '0)
    else $error("compare result has a nonzero fraction");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (.*);
`default_nettype wire
